// ===== rtl/slt_pkg.sv =====
package slt_pkg;

  localparam int unsigned TxDepth = 64;
  localparam int unsigned RxDepth = 8;
  localparam int unsigned TxIdxW  = $clog2(TxDepth + 1);
  localparam int unsigned TxAddrW = $clog2(TxDepth);
  localparam int unsigned RxIdxW  = $clog2(RxDepth + 1);
  localparam int unsigned RxAddrW = $clog2(RxDepth);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CrByte = 8'h0d;
  localparam logic [7:0] LfByte = 8'h0a;

  // operation codes on the input port
  localparam logic [1:0] OpQueue  = 2'd0;
  localparam logic [1:0] OpUpdate = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  // result kinds
  localparam logic [1:0] KindAck  = 2'd0;
  localparam logic [1:0] KindSent = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;

  // error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrFull    = 2'd1;
  localparam logic [1:0] ErrTimeout = 2'd2;

  typedef enum logic [1:0] {
    CMD_QUEUE,
    CMD_UPDATE,
    CMD_READ,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_TX,
    SRC_RX
  } src_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_char;
    logic       rx_present;
    logic [7:0] rx_byte;
    logic       tx_ready;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       char_valid;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_char;
    logic       rx_present;
    logic [7:0] rx_byte;
    logic       tx_ready;
  } cmd_t;

endpackage

// ===== rtl/serial_link_tx_rx_buffer.sv =====
// Buffered serial link: a queue, update or read command is taken when start is
// high and busy low. Commands go through a two-entry command queue to the
// buffer engine, which takes one command at a time from idle and steps through
// an emit state (and a second one when a line feed is sent as carriage return
// plus line feed); the first result appears after the command has passed the
// queue register and the engine state register. Each result is shown for a
// single cycle with valid_o high and must be taken then; nothing on the result
// side can hold it back. busy is high only while the command queue is full.
module serial_link_tx_rx_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  slt_pkg::item_t item_i,
  output logic           valid_o,
  output slt_pkg::res_t  res_o
);

  slt_pkg::cmd_t front_cmd, back_cmd;
  logic          push, pop, q_empty, q_full;

  slt_front u_front (
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  slt_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  slt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (back_cmd),
    .empty_i (q_empty),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

// ===== rtl/slt_front.sv =====
module slt_front (
  input  logic           start,
  output logic           busy,
  input  slt_pkg::item_t item_i,
  input  logic           q_full_i,
  output logic           push_o,
  output slt_pkg::cmd_t  cmd_o
);

  assign busy   = q_full_i;
  assign push_o = start && !q_full_i;

  always_comb begin
    cmd_o.tx_char    = item_i.tx_char;
    cmd_o.rx_present = item_i.rx_present;
    cmd_o.rx_byte    = item_i.rx_byte;
    cmd_o.tx_ready   = item_i.tx_ready;
    unique case (item_i.operation)
      slt_pkg::OpQueue:  cmd_o.cmd = slt_pkg::CMD_QUEUE;
      slt_pkg::OpUpdate: cmd_o.cmd = slt_pkg::CMD_UPDATE;
      slt_pkg::OpRead:   cmd_o.cmd = slt_pkg::CMD_READ;
      default:           cmd_o.cmd = slt_pkg::CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/slt_cmd_fifo.sv =====
module slt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slt_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output slt_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);

  slt_pkg::cmd_t                 mem_q [slt_pkg::QDepth];
  logic [slt_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [slt_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [slt_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == slt_pkg::QCntW'(slt_pkg::QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == slt_pkg::QPtrW'(slt_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == slt_pkg::QPtrW'(slt_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/slt_back.sv =====
module slt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  output slt_pkg::res_t res_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEmit   = 2'd1;
  localparam logic [1:0] StEmitLf = 2'd2;

  logic [1:0] state_q, state_d;

  logic [7:0] tx_mem [slt_pkg::TxDepth];
  logic [7:0] rx_mem [slt_pkg::RxDepth];
  logic [7:0] tx_rd_q, rx_rd_q;

  logic [slt_pkg::TxIdxW-1:0] tx_fill_q, tx_fill_d, tx_sent_q, tx_sent_d;
  logic [slt_pkg::RxIdxW-1:0] rx_fill_q, rx_fill_d, rx_read_q, rx_read_d, rx_base;

  logic tx_wr, tx_rd, rx_wr, rx_rd;
  logic [slt_pkg::TxAddrW-1:0] tx_wr_addr, tx_rd_addr;
  logic [slt_pkg::RxAddrW-1:0] rx_wr_addr, rx_rd_addr;

  slt_pkg::src_e src_q, src_d;
  logic [1:0]    kind_q, kind_d, err_q, err_d;
  logic          cvalid_q, cvalid_d;
  logic          tx_is_lf;

  assign pop_o = (state_q == StIdle) && !empty_i;

  always_comb begin
    tx_fill_d  = tx_fill_q;
    tx_sent_d  = tx_sent_q;
    rx_fill_d  = rx_fill_q;
    rx_read_d  = rx_read_q;
    tx_wr      = 1'b0;
    tx_rd      = 1'b0;
    rx_wr      = 1'b0;
    rx_rd      = 1'b0;
    tx_wr_addr = tx_fill_q[slt_pkg::TxAddrW-1:0];
    tx_rd_addr = tx_sent_q[slt_pkg::TxAddrW-1:0];
    rx_rd_addr = rx_read_q[slt_pkg::RxAddrW-1:0];
    rx_base    = (rx_fill_q == rx_read_q) ? '0 : rx_fill_q;
    rx_wr_addr = rx_base[slt_pkg::RxAddrW-1:0];
    src_d      = slt_pkg::SRC_ZERO;
    kind_d     = slt_pkg::KindAck;
    err_d      = slt_pkg::ErrNone;
    cvalid_d   = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.cmd)
        slt_pkg::CMD_QUEUE: begin
          if (tx_fill_q < slt_pkg::TxIdxW'(slt_pkg::TxDepth)) begin
            tx_wr     = 1'b1;
            tx_fill_d = tx_fill_q + 1'b1;
          end else begin
            err_d = slt_pkg::ErrFull;
          end
        end
        slt_pkg::CMD_UPDATE: begin
          if (tx_sent_q < tx_fill_q) begin
            tx_rd     = 1'b1;
            tx_sent_d = tx_sent_q + 1'b1;
            if (!cmd_i.tx_ready) begin
              err_d = slt_pkg::ErrTimeout;
            end else begin
              kind_d = slt_pkg::KindSent;
              src_d  = slt_pkg::SRC_TX;
            end
          end else begin
            tx_fill_d = '0;
            tx_sent_d = '0;
          end
          if (cmd_i.rx_present) begin
            // empty receive buffer rewinds to the start before storing
            if (rx_fill_q == rx_read_q) begin
              rx_read_d = '0;
            end
            rx_fill_d = rx_base;
            if (rx_base < slt_pkg::RxIdxW'(slt_pkg::RxDepth)) begin
              rx_wr     = 1'b1;
              rx_fill_d = rx_base + 1'b1;
            end
          end
        end
        slt_pkg::CMD_READ: begin
          kind_d = slt_pkg::KindRead;
          if (rx_read_q < rx_fill_q) begin
            rx_rd     = 1'b1;
            rx_read_d = rx_read_q + 1'b1;
            src_d     = slt_pkg::SRC_RX;
            cvalid_d  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tx_is_lf = (src_q == slt_pkg::SRC_TX) && (tx_rd_q == slt_pkg::LfByte);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (pop_o) state_d = StEmit;
      StEmit:   state_d = tx_is_lf ? StEmitLf : StIdle;
      StEmitLf: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    valid_o          = (state_q == StEmit) || (state_q == StEmitLf);
    res_o.kind       = kind_q;
    res_o.char_valid = cvalid_q;
    res_o.error_code = err_q;
    res_o.last       = 1'b1;
    case (src_q)
      slt_pkg::SRC_TX: res_o.byte_out = tx_rd_q;
      slt_pkg::SRC_RX: res_o.byte_out = rx_rd_q;
      default:         res_o.byte_out = 8'h00;
    endcase
    // line feed goes out as carriage return, then line feed
    if (state_q == StEmitLf) begin
      res_o.byte_out = slt_pkg::LfByte;
    end else if (tx_is_lf) begin
      res_o.byte_out = slt_pkg::CrByte;
      res_o.last     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      tx_fill_q <= '0;
      tx_sent_q <= '0;
      rx_fill_q <= '0;
      rx_read_q <= '0;
    end else begin
      state_q   <= state_d;
      tx_fill_q <= tx_fill_d;
      tx_sent_q <= tx_sent_d;
      rx_fill_q <= rx_fill_d;
      rx_read_q <= rx_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      src_q    <= src_d;
      kind_q   <= kind_d;
      err_q    <= err_d;
      cvalid_q <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_wr) begin
      tx_mem[tx_wr_addr] <= cmd_i.tx_char;
    end
    if (tx_rd) begin
      tx_rd_q <= tx_mem[tx_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_wr) begin
      rx_mem[rx_wr_addr] <= cmd_i.rx_byte;
    end
    if (rx_rd) begin
      rx_rd_q <= rx_mem[rx_rd_addr];
    end
  end

  a_tx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_sent_q <= tx_fill_q) else $error("transmit send index passed fill index");

  a_rx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_read_q <= rx_fill_q) else $error("receive read index passed fill index");

  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fill_q <= slt_pkg::RxIdxW'(slt_pkg::RxDepth)) else $error("receive fill overrun");

  a_lf_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitLf) |-> $past(state_q == StEmit))
    else $error("line feed emitted without its carriage return");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !pop_o) else $error("command taken while a result is on the port");

endmodule
